FILE: hw/rtl/cial_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cial_pkg: shared definitions for the card ID access list
// Sizes, operation and status codes, the sequencer states, the store request
// bundle and the UID byte weights.
// ----------------------------------------------------------------------------
package cial_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ID_W     = 15;
  localparam int POS_W    = 9;
  localparam int KIND_W   = 2;
  localparam int STAT_W   = 3;
  localparam int BYTE_W   = 8;
  localparam int NBYTES   = 4;

  // Operation codes carried in the input tuser field.
  localparam logic [KIND_W-1:0] KIND_CHECK   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ADD     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DEL_ID  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DEL_POS = 2'd3;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
  localparam logic [STAT_W-1:0] STAT_ABSENT  = 3'd1;
  localparam logic [STAT_W-1:0] STAT_PRESENT = 3'd2;
  localparam logic [STAT_W-1:0] STAT_MASTER  = 3'd3;
  localparam logic [STAT_W-1:0] STAT_FULL    = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_DECIDE,
    ST_SCAN,
    ST_SHIFT_GO,
    ST_SHIFT,
    ST_RESULT
  } cial_state_t;

  // One write port and one read address towards the card store.
  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ID_W-1:0]   wdata;
    logic [ADDR_W-1:0] raddr;
  } cial_mem_req_t;

  // Weight of each UID byte in the folded card ID.
  function automatic logic [4:0] byte_weight(input logic [1:0] sel);
    logic [4:0] w;
    case (sel)
      2'd0:    w = 5'd25;
      2'd1:    w = 5'd22;
      2'd2:    w = 5'd19;
      2'd3:    w = 5'd16;
      default: w = 5'd0;
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/cial_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cial_store: card ID storage
// Single write port and one registered read port over the list entries.
// ----------------------------------------------------------------------------
module cial_store
  import cial_pkg::*;
(
  input  logic            clk,
  input  cial_mem_req_t   req,
  output logic [ID_W-1:0] rdata
);

  logic [ID_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[req.raddr];
  end

endmodule

FILE: hw/rtl/card_id_access_list.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// card_id_access_list: ordered card ID list behind a protected master card
// Folds four UID bytes into a card ID, then checks, adds or deletes it in a
// compacting list held in a single-port-write store.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Handshake           Contents
// in_       slave      tvalid/tready       tdata: uid_byte0..3, position
//                                          tuser: kind
// out_      master     tvalid/tready       tdata: status, card_id, entry_count
// cfg_      slave      valid/ready         data: master_id
//
// An operation starts when its word is accepted, then folds the UID bytes one
// at a time with one constant multiplier and adder, decides, searches the list
// through the store read port one entry per cycle (up to 256 entries), and
// moves one entry per cycle when a deletion closes the gap (up to 255), then
// ends in the result state. The search stops at the entry where compaction
// starts, so the two together walk the list at most once. The store read port
// sets the pace.
// Reset is synchronous and active low; it empties the list at once, since
// a fill count guards the store and no clearing pass is needed.
// A new word is taken only while the sequencer is idle, which includes the
// time that a finished result waits for out_tready in the output register.
// The configuration port is always ready and should only be written while
// no operation is in flight.
// ----------------------------------------------------------------------------
module card_id_access_list
  import cial_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input word
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [47:0]       in_tdata,   // uid_byte0, uid_byte1, uid_byte2, uid_byte3, position
  input  logic [KIND_W-1:0] in_tuser,   // kind
  // result word
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [31:0]       out_tdata,  // status, card_id, entry_count
  // master card register
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [ID_W-1:0]   cfg_data
);

  cial_state_t state_r, state_nxt;

  logic [KIND_W-1:0] kind_r;
  logic [BYTE_W-1:0] bytes_r [NBYTES];
  logic [POS_W-1:0]  pos_r;
  logic [1:0]        step_r, step_nxt;
  logic [ID_W-1:0]   acc_r, acc_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [ID_W-1:0]   master_r;

  logic              out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0] out_status_r;
  logic [ID_W-1:0]   out_id_r;
  logic [CNT_W-1:0]  out_count_r;
  logic              out_load;

  cial_mem_req_t     mem_req;
  logic [ID_W-1:0]   rdata;

  logic              in_fire;
  logic              hit, miss;
  logic [12:0]       product;
  logic [CNT_W-1:0]  idx_ext;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, out_count_r, out_id_r, out_status_r};

  // The shared folding unit: one byte times its constant weight per cycle.
  assign product = bytes_r[step_r] * byte_weight(step_r);
  assign idx_ext = CNT_W'(idx_r);

  cial_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (rdata)
  );

  // Capture the input word and the master card register.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_r     <= in_tuser;
      bytes_r[0] <= in_tdata[7:0];
      bytes_r[1] <= in_tdata[15:8];
      bytes_r[2] <= in_tdata[23:16];
      bytes_r[3] <= in_tdata[31:24];
      pos_r      <= in_tdata[40:32];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      master_r <= cfg_data;
    end
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r   <= step_nxt;
    acc_r    <= acc_nxt;
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    if (out_load) begin
      out_status_r <= status_r;
      out_id_r     <= acc_r;
      out_count_r  <= count_r;
    end
  end

  // Next state and store control.
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    acc_nxt       = acc_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    status_nxt    = status_r;
    mem_req       = '0;
    hit           = 1'b0;
    miss          = 1'b0;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          step_nxt  = '0;
          acc_nxt   = '0;
          state_nxt = ST_CALC;
        end
      end

      ST_CALC: begin
        acc_nxt  = acc_r + ID_W'(product);
        step_nxt = step_r + 2'd1;
        if (step_r == 2'd3) begin
          state_nxt = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        if (kind_r == KIND_DEL_POS) begin
          if (pos_r == '0) begin
            status_nxt = STAT_MASTER;
            state_nxt  = ST_RESULT;
          end else if (pos_r > count_r) begin
            status_nxt = STAT_ABSENT;
            state_nxt  = ST_RESULT;
          end else begin
            idx_nxt   = ADDR_W'(pos_r - POS_W'(1));
            state_nxt = ST_SHIFT_GO;
          end
        end else if (acc_r == master_r) begin
          case (kind_r)
            KIND_CHECK:  status_nxt = STAT_OK;
            KIND_ADD:    status_nxt = STAT_PRESENT;
            default:     status_nxt = STAT_MASTER;
          endcase
          state_nxt = ST_RESULT;
        end else if (count_r == '0) begin
          miss = 1'b1;
        end else begin
          mem_req.raddr = '0;
          idx_nxt       = '0;
          state_nxt     = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // rdata holds the entry at idx_r.
        if (rdata == acc_r) begin
          hit = 1'b1;
        end else if (idx_ext + CNT_W'(1) == count_r) begin
          miss = 1'b1;
        end else begin
          mem_req.raddr = idx_r + ADDR_W'(1);
          idx_nxt       = idx_r + ADDR_W'(1);
        end
      end

      ST_SHIFT_GO: begin
        if (idx_ext + CNT_W'(1) >= count_r) begin
          count_nxt  = count_r - CNT_W'(1);
          status_nxt = STAT_OK;
          state_nxt  = ST_RESULT;
        end else begin
          mem_req.raddr = idx_r + ADDR_W'(1);
          state_nxt     = ST_SHIFT;
        end
      end

      ST_SHIFT: begin
        // rdata holds the entry at idx_r + 1, moved down one slot.
        mem_req.we    = 1'b1;
        mem_req.waddr = idx_r;
        mem_req.wdata = rdata;
        idx_nxt       = idx_r + ADDR_W'(1);
        if (idx_ext + CNT_W'(2) >= count_r) begin
          count_nxt  = count_r - CNT_W'(1);
          status_nxt = STAT_OK;
          state_nxt  = ST_RESULT;
        end else begin
          mem_req.raddr = idx_r + ADDR_W'(2);
        end
      end

      ST_RESULT: begin
        if (!out_valid_r || out_tready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (hit) begin
      case (kind_r)
        KIND_CHECK: begin
          status_nxt = STAT_OK;
          state_nxt  = ST_RESULT;
        end
        KIND_ADD: begin
          status_nxt = STAT_PRESENT;
          state_nxt  = ST_RESULT;
        end
        default: begin
          state_nxt = ST_SHIFT_GO;
        end
      endcase
    end

    if (miss) begin
      state_nxt = ST_RESULT;
      if (kind_r == KIND_ADD) begin
        if (count_r >= CNT_W'(CAPACITY)) begin
          status_nxt = STAT_FULL;
        end else begin
          mem_req.we    = 1'b1;
          mem_req.waddr = count_r[ADDR_W-1:0];
          mem_req.wdata = acc_r;
          count_nxt     = count_r + CNT_W'(1);
          status_nxt    = STAT_OK;
        end
      end else begin
        status_nxt = STAT_ABSENT;
      end
    end
  end

  // The list never grows past the store.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count beyond capacity");

  // An accepted word always starts the folding unit.
  a_accept_calc: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == ST_CALC)
    else $error("accepted word did not start folding");

  // Compaction writes only inside the occupied part of the list.
  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SHIFT |-> idx_ext + CNT_W'(1) < count_r)
    else $error("compaction outside the list");

  // A result is only presented out of the result state.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_RESULT))
    else $error("result raised outside the result state");

  // The entry count only moves in the decide, search and compaction states.
  a_count_move: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != $past(count_r) |->
      ($past(state_r) == ST_SCAN || $past(state_r) == ST_DECIDE ||
       $past(state_r) == ST_SHIFT_GO || $past(state_r) == ST_SHIFT))
    else $error("entry count changed outside an update");

endmodule
